// File: rtl/fmwm_pkg.sv
`default_nettype none
package fmwm_pkg;

  localparam int HISTORY_DEPTH_DEF = 256;

  localparam int TIMES_W = 48;
  localparam int LOADS_W = 60;
  localparam int ACC_W   = 28;
  localparam int IN_W    = 112;
  localparam int OUT_W   = 120;
  localparam int CFG_AW  = 2;

  localparam logic [CFG_AW-1:0] CFG_AVG_WINDOW = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_MAX_ISSUES = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_TARGET_FPS = 2'd2;

  localparam logic [15:0] LOW_FPS_LIMIT    = 16'd1280;
  localparam logic [15:0] HIGH_LAT_LIMIT   = 16'd5120;
  localparam logic [15:0] GPU_BOTTLE_LIMIT = 16'd24320;
  localparam logic [15:0] HIGH_MEM_LIMIT   = 16'd4096;
  localparam logic [15:0] FOV_FPS_LIMIT    = 16'd1360;
  localparam logic [15:0] FOV_GPU_LIMIT    = 16'd21760;
  localparam logic [15:0] RAISE_GPU_LIMIT  = 16'd17920;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_DIV,
    ST_FLAGS,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [ACC_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [ACC_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/fmwm_ram.sv
`default_nettype none
module fmwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/fmwm_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle; divisor held by caller.
module fmwm_div import fmwm_pkg::*; #(
  parameter int NW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire div_req_t      req,
  input  wire logic [NW-1:0] divisor,
  output div_rsp_t           rsp
);
  localparam int CW = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] quot_r, quot_nxt;
  logic [NW:0]      rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic [NW+1:0]    trial;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(ACC_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract when it fits
      trial    = {rem_r, quot_r[ACC_W-1]} - {2'b00, divisor};
      if (!trial[NW+1]) begin
        rem_nxt  = trial[NW:0];
        quot_nxt = {quot_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_nxt  = {rem_r[NW-1:0], quot_r[ACC_W-1]};
        quot_nxt = {quot_r[ACC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
endmodule
`default_nettype wire

// File: rtl/frame_metrics_window_monitor_top.sv
`default_nettype none
// Frame metrics window monitor. Each input word is one frame record; it is
// written to a history ring, then the newest avg_window records (whole
// history when avg_window is 0 or above the fill) are read back one at a
// time: each record is read, then its seven fields pass through a single
// shared adder into seven sums. One serial divider then turns the sums into
// means one after another (each: start, 28 quotient bits, done).
// Issue flags, foveation hint and quality action follow from the means.
// out_tvalid rises once the result word is registered from the means and
// flags; in_tready is low from the taken input word until then and rises
// again the cycle after the result word is taken.
// Ring contents need no clearing after reset.
module frame_metrics_window_monitor_top import fmwm_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // frame_time, render_time, frame_latency, frame_rate, gpu_load,
  // cpu_load, memory_mb (low bits first)
  input  wire logic [IN_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // mean_frame_time, mean_render_time, mean_latency, mean_rate,
  // mean_gpu_load, mean_cpu_load, mean_memory, issue_mask, issue_total,
  // foveate_hint, quality_action, zero pad (low bits first)
  output logic      [OUT_W-1:0]  out_tdata,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_AW-1:0] cfg_index,
  input  wire logic [13:0]       cfg_data
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int NW = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = (NW > 9) ? NW : 9;

  state_t state_r, state_nxt;

  logic [8:0]  avg_window_r;
  logic [2:0]  max_issues_r;
  logic [13:0] target_fps_r;
  logic [AW-1:0] wslot_r;
  logic [NW-1:0] fill_r, fill_new, n_r, cnt_r;
  logic [AW-1:0] raddr_r;
  logic [ACC_W-1:0] sum_r [7];
  logic [15:0]      mean_r [7];
  logic [2:0]       sel_r;
  logic [TIMES_W-1:0] t_rd;
  logic [LOADS_W-1:0] l_rd;
  logic [OUT_W-1:0]   out_r;
  logic               out_v_r;
  logic               div_go_r;
  div_req_t dreq;
  div_rsp_t drsp;
  logic in_acc, out_acc;
  logic [15:0] fld [7];
  logic [ACC_W-1:0] add_a, add_b, add_y;
  logic [3:0] mask;
  logic [2:0] total;
  logic fov;
  logic [1:0] action;
  logic [17:0] r10, t9, t11;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (state_r == ST_IDLE) && !out_v_r;
  assign cfg_ready = 1'b1;

  fmwm_ram #(.WIDTH(TIMES_W), .DEPTH(HISTORY_DEPTH)) u_times (
    .clk, .we(in_acc), .waddr(wslot_r), .wdata(in_tdata[47:0]),
    .raddr(raddr_r), .rdata(t_rd));
  fmwm_ram #(.WIDTH(LOADS_W), .DEPTH(HISTORY_DEPTH)) u_loads (
    .clk, .we(in_acc), .waddr(wslot_r), .wdata(in_tdata[107:48]),
    .raddr(raddr_r), .rdata(l_rd));

  fmwm_div #(.NW(NW)) u_div (.clk, .rst_n, .req(dreq), .divisor(n_r), .rsp(drsp));

  // unpack read record
  always_comb begin
    fld[0] = t_rd[15:0];
    fld[1] = t_rd[31:16];
    fld[2] = t_rd[47:32];
    fld[3] = {2'b00, l_rd[13:0]};
    fld[4] = {1'b0, l_rd[28:14]};
    fld[5] = {1'b0, l_rd[43:29]};
    fld[6] = l_rd[59:44];
  end

  // shared adder, one field per cycle while in ST_ACC
  assign add_a = sum_r[sel_r];
  assign add_b = ACC_W'(fld[sel_r]);
  assign add_y = add_a + add_b;

  assign fill_new = (fill_r == NW'(HISTORY_DEPTH)) ? fill_r : fill_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_ACC;
      ST_ACC:   if (sel_r == 3'd6 && cnt_r == NW'(1)) state_nxt = ST_DIV;
                else if (sel_r == 3'd6) state_nxt = ST_READ;
      ST_DIV:   if (drsp.done && sel_r == 3'd6) state_nxt = ST_FLAGS;
      ST_FLAGS: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // divider start, driven from the registered kick while the divider is not busy
  always_comb begin
    dreq.start    = div_go_r && !drsp.busy;
    dreq.dividend = sum_r[sel_r];
  end

  // flags and actions
  always_comb begin
    mask  = '0;
    total = '0;
    if (mean_r[3] < LOW_FPS_LIMIT && total < max_issues_r) begin
      mask[0] = 1'b1; total = total + 1'b1;
    end
    if (mean_r[2] > HIGH_LAT_LIMIT && total < max_issues_r) begin
      mask[1] = 1'b1; total = total + 1'b1;
    end
    if (mean_r[4] > GPU_BOTTLE_LIMIT && total < max_issues_r) begin
      mask[2] = 1'b1; total = total + 1'b1;
    end
    if (mean_r[6] > HIGH_MEM_LIMIT && total < max_issues_r) begin
      mask[3] = 1'b1; total = total + 1'b1;
    end
    fov = (mean_r[3] < FOV_FPS_LIMIT) || (mean_r[4] > FOV_GPU_LIMIT);
    r10 = 18'(mean_r[3]) * 18'd10;
    t9  = 18'(target_fps_r) * 18'd9;
    t11 = 18'(target_fps_r) * 18'd11;
    if (r10 < t9) action = 2'd1;
    else if (r10 > t11 && mean_r[4] < RAISE_GPU_LIMIT) action = 2'd2;
    else action = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      avg_window_r <= 9'd60;
      max_issues_r <= 3'd4;
      target_fps_r <= 14'd1440;
      wslot_r      <= '0;
      fill_r       <= '0;
      out_v_r      <= 1'b0;
      div_go_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_AVG_WINDOW: avg_window_r <= cfg_data[8:0];
          CFG_MAX_ISSUES: max_issues_r <= cfg_data[2:0];
          CFG_TARGET_FPS: target_fps_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        wslot_r <= (wslot_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wslot_r + 1'b1;
        fill_r  <= fill_new;
      end
      if (state_r == ST_OUT) out_v_r <= 1'b1;
      else if (out_acc) out_v_r <= 1'b0;
      div_go_r <= (state_r == ST_ACC && state_nxt == ST_DIV) ||
                  (state_r == ST_DIV && drsp.done && sel_r != 3'd6);
    end
  end

  // window length and first ring slot of the window
  logic [NW-1:0] n_pick;
  logic [NW:0]   start_idx;
  logic [AW-1:0] start_slot;
  always_comb begin
    n_pick = (avg_window_r == 9'd0 || CMP_W'(avg_window_r) > CMP_W'(fill_new)) ?
             fill_new : NW'(avg_window_r);
    start_idx = (NW+1)'(wslot_r) + (NW+1)'(HISTORY_DEPTH + 1) - (NW+1)'(n_pick);
    start_slot = (start_idx >= (NW+1)'(HISTORY_DEPTH)) ?
                 AW'(start_idx - (NW+1)'(HISTORY_DEPTH)) : AW'(start_idx);
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      n_r     <= n_pick;
      cnt_r   <= n_pick;
      raddr_r <= start_slot;
      sel_r   <= '0;
      for (int i = 0; i < 7; i++) sum_r[i] <= '0;
    end else if (state_r == ST_ACC) begin
      sum_r[sel_r] <= add_y;
      if (sel_r == 3'd6) begin
        sel_r <= '0;
        cnt_r <= cnt_r - 1'b1;
        raddr_r <= (raddr_r == AW'(HISTORY_DEPTH - 1)) ? '0 : raddr_r + 1'b1;
      end else begin
        sel_r <= sel_r + 1'b1;
      end
    end else if (state_r == ST_DIV && drsp.done) begin
      mean_r[sel_r] <= drsp.quot[15:0];
      if (sel_r != 3'd6) sel_r <= sel_r + 1'b1;
    end
    if (state_r == ST_FLAGS)
      out_r <= {2'd0, action, fov, total, mask, mean_r[6], mean_r[5][14:0],
                mean_r[4][14:0], mean_r[3][13:0], mean_r[2], mean_r[1], mean_r[0]};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // assertions
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("out changed");
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= NW'(HISTORY_DEPTH)) else $error("fill overflow");
endmodule
`default_nettype wire
